// ----- design/tpat_pkg.sv -----
// ---------------------------------------------------------------------------
// tpat_pkg: shared types and constants of the address translator
// address layout, default sizes, and the controller/datapath command and
// status structs
// ---------------------------------------------------------------------------
`default_nettype none

package tpat_pkg;

    // fixed address layout
    localparam int ADDR_W     = 16;
    localparam int PAGE_BYTES = 256;
    localparam int OFFSET_W   = $clog2(PAGE_BYTES);
    localparam int RAW_PAGE_W = ADDR_W - OFFSET_W;
    localparam int CNT_W      = 32;

    // default sizes of the stores
    localparam int TLB_ENTRIES_DEF = 32;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int FRAME_COUNT_DEF = 256;

    // one result item
    typedef struct packed {
        logic [ADDR_W-1:0] physical_address;
        logic              tlb_hit;
        logic              fault_flag;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  miss_total;
        logic [CNT_W-1:0]  fault_total;
    } tpat_result_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;   // write one zero entry of the page table
        logic capture;      // take the input item
        logic pt_read;      // read the page table entry of the held page
        logic commit_hit;   // finish a tlb hit
        logic commit_miss;  // finish a miss from the page table entry
    } tpat_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;   // clearing pass is at its last entry
        logic tlb_hit;      // held page is in the tlb
        logic out_free;     // output register can take a result
    } tpat_status_t;

endpackage

`default_nettype wire

// ----- design/tpat_in_if.sv -----
// ---------------------------------------------------------------------------
// tpat_in_if: input channel of the address translator
// valid/ready handshake carrying one logical address per item
// ---------------------------------------------------------------------------
`default_nettype none

interface tpat_in_if;
    import tpat_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] logical_address;

    modport source (output valid, output logical_address, input ready);
    modport sink   (input valid, input logical_address, output ready);
endinterface

`default_nettype wire

// ----- design/tpat_out_if.sv -----
// ---------------------------------------------------------------------------
// tpat_out_if: result channel of the address translator
// valid/ready handshake carrying the translated address, flags and totals
// ---------------------------------------------------------------------------
`default_nettype none

interface tpat_out_if;
    import tpat_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] physical_address;
    logic              tlb_hit;
    logic              fault_flag;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  fault_total;

    modport source (
        output valid, output physical_address, output tlb_hit, output fault_flag,
        output hit_total, output miss_total, output fault_total, input ready
    );
    modport sink (
        input valid, input physical_address, input tlb_hit, input fault_flag,
        input hit_total, input miss_total, input fault_total, output ready
    );
endinterface

`default_nettype wire

// ----- design/tpat_ram.sv -----
// ---------------------------------------------------------------------------
// tpat_ram: generic single-write, single-read ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module tpat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/tpat_ctrl.sv -----
// ---------------------------------------------------------------------------
// tpat_ctrl: sequencing state machine of the address translator
// clearing pass, item capture, tlb lookup and page table walk
// ---------------------------------------------------------------------------
`default_nettype none

module tpat_ctrl
    import tpat_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire tpat_status_t status,
    output tpat_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (status.tlb_hit)
                begin
                    if (status.out_free)
                    begin
                        cmd.commit_hit = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.pt_read = 1'b1;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // read data holds until the result can be placed
                if (status.out_free)
                begin
                    cmd.commit_miss = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/tpat_datapath.sv -----
// ---------------------------------------------------------------------------
// tpat_datapath: tlb, page table, counters and output register
// acts on commands from the controller and reports status back
// ---------------------------------------------------------------------------
`default_nettype none

module tpat_datapath
    import tpat_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tpat_cmd_t         cmd,
    output tpat_status_t           status,
    input  wire logic [ADDR_W-1:0] logical_address,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tpat_result_t           result
);

    localparam int PW   = $clog2(PAGE_COUNT);
    localparam int FW   = $clog2(FRAME_COUNT);
    localparam int VW   = $clog2(TLB_ENTRIES);
    localparam int REMW = RAW_PAGE_W + 6;

    // held item
    logic [PW-1:0]       page_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [PW-1:0]       page_mod;

    // tlb
    logic          tlb_valid_reg [TLB_ENTRIES];
    logic [PW-1:0] tlb_tag_reg   [TLB_ENTRIES];
    logic [FW-1:0] tlb_data_reg  [TLB_ENTRIES];
    logic [VW-1:0] victim_reg;
    logic          hit;
    logic [FW-1:0] hit_frame;

    // page table and frame allocation
    logic [PW-1:0] clear_cnt_reg;
    logic [FW-1:0] next_frame_reg;
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [FW:0]   ram_wdata;
    logic [FW:0]   ram_rdata;
    logic          fault;
    logic [FW-1:0] walk_frame;
    logic [FW-1:0] frame;

    // counters and output
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] fault_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_next;
    logic [CNT_W-1:0] fault_cnt_next;
    logic             out_valid_reg;
    logic             load;
    tpat_result_t     result_reg;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // page number modulo the table size, quotient is at most fifteen
    always_comb
    begin
        logic [REMW-1:0] rem;
        rem = REMW'(logical_address[ADDR_W-1:OFFSET_W]);
        for (int k = 3; k >= 0; k--)
        begin
            if (rem >= (REMW'(PAGE_COUNT) << k))
            begin
                rem = rem - (REMW'(PAGE_COUNT) << k);
            end
        end
        page_mod = PW'(rem);
    end

    // fully associative match, tags are unique so the hits can be or-ed
    always_comb
    begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            if (tlb_valid_reg[i] && (tlb_tag_reg[i] == page_reg))
            begin
                hit       = 1'b1;
                hit_frame = hit_frame | tlb_data_reg[i];
            end
        end
    end

    assign fault      = !ram_rdata[FW];
    assign walk_frame = fault ? next_frame_reg : ram_rdata[FW-1:0];
    assign frame      = cmd.commit_hit ? hit_frame : walk_frame;
    assign load       = cmd.commit_hit || cmd.commit_miss;

    assign ram_we    = cmd.clear_step || (cmd.commit_miss && fault);
    assign ram_waddr = cmd.clear_step ? clear_cnt_reg : page_reg;
    assign ram_wdata = cmd.clear_step ? '0 : {1'b1, next_frame_reg};

    tpat_ram #(
        .WIDTH (FW + 1),
        .DEPTH (PAGE_COUNT)
    ) u_page_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.pt_read),
        .raddr (page_reg),
        .rdata (ram_rdata)
    );

    assign hit_cnt_next   = cmd.commit_hit ? sat_inc(hit_cnt_reg) : hit_cnt_reg;
    assign miss_cnt_next  = cmd.commit_miss ? sat_inc(miss_cnt_reg) : miss_cnt_reg;
    assign fault_cnt_next = (cmd.commit_miss && fault) ? sat_inc(fault_cnt_reg)
                                                       : fault_cnt_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg  <= '0;
            victim_reg     <= '0;
            next_frame_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            fault_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                tlb_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (cmd.commit_miss)
            begin
                tlb_valid_reg[victim_reg] <= 1'b1;
                victim_reg <= (victim_reg == VW'(TLB_ENTRIES - 1)) ? '0
                                                                   : victim_reg + 1'b1;
                if (fault)
                begin
                    next_frame_reg <= (next_frame_reg == FW'(FRAME_COUNT - 1)) ? '0
                                      : next_frame_reg + 1'b1;
                end
            end
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg   <= page_mod;
            offset_reg <= logical_address[OFFSET_W-1:0];
        end
        if (cmd.commit_miss)
        begin
            tlb_tag_reg[victim_reg]  <= page_reg;
            tlb_data_reg[victim_reg] <= walk_frame;
        end
        if (load)
        begin
            result_reg.physical_address <= ADDR_W'({frame, offset_reg});
            result_reg.tlb_hit          <= cmd.commit_hit;
            result_reg.fault_flag       <= cmd.commit_miss && fault;
            result_reg.hit_total        <= hit_cnt_next;
            result_reg.miss_total       <= miss_cnt_next;
            result_reg.fault_total      <= fault_cnt_next;
        end
    end

    assign status.clear_last = (clear_cnt_reg == PW'(PAGE_COUNT - 1));
    assign status.tlb_hit    = hit;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// ----- design/tlb_page_table_address_translator.sv -----
// ---------------------------------------------------------------------------
// tlb_page_table_address_translator: tlb and demand paging address translator
// hit: the result is loaded into the output register from the lookup state,
//   miss: from the walk state after the registered read of the page table ram;
//   both wait while the output register is full; items are taken only in idle
// reset: a clearing pass zeroes the page table valid bits, during which no
//   item is accepted
// ---------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_address_translator
    import tpat_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tpat_in_if.sink     addr_ch,
    tpat_out_if.source  result_ch
);

    // command and status between the sequencer and the datapath
    tpat_cmd_t    cmd;
    tpat_status_t status;
    tpat_result_t result;

    // the controller walks clear, idle, lookup and walk states; an item is
    // taken only in idle, while a finished result may still sit in the
    // output register waiting for the sink
    tpat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (addr_ch.valid),
        .in_ready (addr_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // the datapath holds the tlb in flip-flops (parallel tag match), the
    // page table in a ram with a valid bit per entry, the fifo victim
    // pointer, the wrapping frame counter and the saturating totals
    tpat_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_COUNT  (PAGE_COUNT),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .logical_address (addr_ch.logical_address),
        .out_valid       (result_ch.valid),
        .out_ready       (result_ch.ready),
        .result          (result)
    );

    // result item fields
    assign result_ch.physical_address = result.physical_address;
    assign result_ch.tlb_hit          = result.tlb_hit;
    assign result_ch.fault_flag       = result.fault_flag;
    assign result_ch.hit_total        = result.hit_total;
    assign result_ch.miss_total       = result.miss_total;
    assign result_ch.fault_total      = result.fault_total;

endmodule

`default_nettype wire
